>>> hdl/nlc_pkg.sv
// nlc_pkg: types and constants for the numeric lexeme classifier
// used by nlc_step and numeric_lexeme_classifier; no dependencies
`default_nettype none

package nlc_pkg;

    localparam int CP_W  = 21;
    localparam int ID_W  = 32;
    localparam int CFG_W = 32;

    // character codes
    localparam logic [CP_W-1:0] CH_COMMA = 21'h00002C;
    localparam logic [CP_W-1:0] CH_DOT   = 21'h00002E;
    localparam logic [CP_W-1:0] CH_LOW_E = 21'h000065;
    localparam logic [CP_W-1:0] CH_UP_E  = 21'h000045;
    localparam logic [CP_W-1:0] CH_PLUS  = 21'h00002B;
    localparam logic [CP_W-1:0] CH_MINUS = 21'h00002D;
    localparam logic [CP_W-1:0] CH_ZERO  = 21'h000030;
    localparam logic [CP_W-1:0] CH_NINE  = 21'h000039;

    // largest id value that may still take one more digit
    localparam logic [ID_W-1:0] ID_GROW_MAX = 32'd429496728;

    localparam logic [2:0] GROUP_LEN = 3'd3;
    localparam logic [2:0] GROUP_SAT = 3'd4;

    // character position within the lexeme
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ID_CHAR    = 2'd0;
    localparam logic [1:0] CFG_INT_COMMAS = 2'd1;
    localparam logic [1:0] CFG_FRAC_COMMAS = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_ID   = 2'd1;
    localparam logic [1:0] KIND_NUM  = 2'd2;

    typedef enum logic [1:0] {
        PATH_UNDECIDED = 2'd0,
        PATH_ID        = 2'd1,
        PATH_NUMBER    = 2'd2,
        PATH_ID_FAILED = 2'd3
    } path_t;

    typedef enum logic [2:0] {
        PH_SIGN       = 3'd0,
        PH_INT        = 3'd1,
        PH_FRAC_START = 3'd2,
        PH_FRAC       = 3'd3,
        PH_EXP_START  = 3'd4,
        PH_EXP_SIGN   = 3'd5,
        PH_EXP        = 3'd6
    } phase_t;

    typedef struct packed {
        logic [1:0]      position;
        path_t           path;
        phase_t          phase;
        logic [2:0]      group_digits;
        logic            comma_seen;
        logic            mantissa_seen;
        logic            failed;
        logic [ID_W-1:0] id_accum;
    } lex_state_t;

    typedef struct packed {
        logic [CP_W-1:0] id_char;
        logic            int_commas_on;
        logic            frac_commas_on;
    } cfg_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_last;
    } nlc_in_t;

    typedef struct packed {
        logic [CP_W-1:0] char_out;
        logic            keep;
        logic            done_res;
        logic [1:0]      kind;
        logic [ID_W-1:0] id_value;
    } nlc_out_t;

endpackage

`default_nettype wire

>>> hdl/numeric_lexeme_classifier.sv
// numeric_lexeme_classifier: top level, lexeme state, config registers, output buffer
// depends on nlc_pkg and nlc_step
//
// usage
//   s_ channel: one character item per transfer (code point, is_last on the
//   final character of a lexeme). m_ channel: one result item per input item,
//   same order: the character, its keep flag, and on the final item the
//   lexeme kind (text, identifier, number) and the identifier value.
//   cfg channel: register writes by index (0 id_char, 1 int_commas_on,
//   2 frac_commas_on); always ready, other indexes are ignored. Write only
//   while no lexeme is in flight.
// timing
//   m_valid and m_data come from the result register. one item per cycle
//   is sustained while m_ready stays high; the whole character update is one
//   combinational step between the lexeme state registers and the result register.
// stall
//   a two-entry output buffer (result register plus skid register) keeps
//   s_ready high for one more item when m_ready drops; s_ready falls only
//   once both entries hold results.
// reset
//   aresetn low clears the lexeme state, the config registers and both
//   output entries; the block accepts items on the first cycle after reset.
`default_nettype none

module numeric_lexeme_classifier
    import nlc_pkg::*;
(
    input  wire             aclk,
    input  wire             aresetn,
    // character items
    input  wire             s_valid,
    output logic            s_ready,
    input  wire nlc_in_t    s_data,
    // result items
    output logic            m_valid,
    input  wire             m_ready,
    output nlc_out_t        m_data,
    // config writes
    input  wire             cfg_valid,
    output logic            cfg_ready,
    input  wire [1:0]       cfg_index,
    input  wire [CFG_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    lex_state_t state_reg;
    lex_state_t state_next;
    nlc_out_t   step_out;

    // output buffer: main entry drives m_, skid entry catches one stalled item
    nlc_out_t   main_reg;
    logic       main_valid_reg;
    nlc_out_t   skid_reg;
    logic       skid_valid_reg;

    logic       push;
    logic       pop;

    assign s_ready   = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign push      = s_valid && s_ready;
    assign pop       = main_valid_reg && m_ready;
    assign m_valid   = main_valid_reg;
    assign m_data    = main_reg;

    // per-character scan and classification
    nlc_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .din  (s_data),
        .nxt  (state_next),
        .dout (step_out)
    );

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ID_CHAR:     cfg_reg.id_char        <= cfg_data[CP_W-1:0];
                CFG_INT_COMMAS:  cfg_reg.int_commas_on  <= cfg_data[0];
                CFG_FRAC_COMMAS: cfg_reg.frac_commas_on <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // lexeme state advances once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.position      <= POS_FIRST;
            state_reg.path          <= PATH_UNDECIDED;
            state_reg.phase         <= PH_SIGN;
            state_reg.group_digits  <= 3'd0;
            state_reg.comma_seen    <= 1'b0;
            state_reg.mantissa_seen <= 1'b0;
            state_reg.failed        <= 1'b0;
            state_reg.id_accum      <= '0;
        end else if (push) begin
            state_reg <= state_next;
        end
    end

    // output buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (push && !pop) begin
                if (!main_valid_reg) begin
                    main_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (!push && pop) begin
                // skid entry moves up, or the buffer empties
                main_valid_reg <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    // output buffer payload, no reset needed
    always_ff @(posedge aclk) begin
        if (push && (pop || !main_valid_reg)) begin
            main_reg <= step_out;
        end else if (!push && pop) begin
            main_reg <= skid_reg;
        end
        if (push && !pop && main_valid_reg) begin
            skid_reg <= step_out;
        end
    end

    // skid entry is only ever filled behind a full main entry
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid while main entry empty");

    // the final character of a lexeme leaves the scan state cleared
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_data.is_last) |=>
            (state_reg.position == POS_FIRST && !state_reg.failed &&
             state_reg.id_accum == '0))
        else $error("lexeme state not cleared after final item");

    // only final items carry a kind or an id value
    a_kind_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.done_res) |-> (m_data.kind == KIND_TEXT &&
                                           m_data.id_value == '0))
        else $error("kind or id value on an item that is not final");

    // a number lexeme always ends on a kept character
    a_num_keeps_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_NUM) |-> m_data.keep)
        else $error("number kind on a dropped final character");

endmodule

`default_nettype wire

>>> hdl/nlc_step.sv
// nlc_step: one-character update of the lexeme scan state and the result item
// depends on nlc_pkg
`default_nettype none

module nlc_step
    import nlc_pkg::*;
(
    input  wire lex_state_t cur,
    input  wire cfg_t       cfg,
    input  wire nlc_in_t    din,
    output lex_state_t      nxt,
    output nlc_out_t        dout
);

    logic [CP_W-1:0] c;
    logic            last;
    logic            dig;
    logic            sign;
    logic            comma;
    logic            expo;
    logic            keep;
    logic            bad;
    lex_state_t      s;
    logic [ID_W-1:0] acc_mul;

    assign c     = din.code_point;
    assign last  = din.is_last;
    assign dig   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign comma = (c == CH_COMMA);
    assign expo  = (c == CH_LOW_E) || (c == CH_UP_E);

    // times ten as two shifts and an add, plus the digit value
    assign acc_mul = (cur.id_accum << 3) + (cur.id_accum << 1)
                   + {{(ID_W-4){1'b0}}, c[3:0]};

    // next state
    always_comb begin
        s    = cur;
        keep = 1'b0;
        bad  = 1'b0;

        // number grammar scan
        if (!cur.failed) begin
            unique case (cur.phase) inside
                PH_SIGN, PH_INT: begin
                    if (cur.phase == PH_SIGN && sign) begin
                        keep    = 1'b1;
                        s.phase = PH_INT;
                    end else begin
                        s.phase = PH_INT;
                        if (dig) begin
                            if (cur.group_digits < GROUP_SAT) begin
                                s.group_digits = cur.group_digits + 3'd1;
                            end
                            s.mantissa_seen = 1'b1;
                            keep            = 1'b1;
                        end else if (comma) begin
                            if (cur.comma_seen) begin
                                if (cur.group_digits != GROUP_LEN) begin
                                    bad = 1'b1;
                                end
                            end else if (!cfg.int_commas_on || cur.group_digits == 3'd0
                                         || cur.group_digits > GROUP_LEN) begin
                                bad = 1'b1;
                            end else begin
                                s.comma_seen = 1'b1;
                            end
                            s.group_digits = 3'd0;
                        end else if (cur.comma_seen && cur.group_digits != GROUP_LEN) begin
                            bad = 1'b1;
                        end else if (c == CH_DOT) begin
                            keep           = 1'b1;
                            s.phase        = PH_FRAC_START;
                            s.group_digits = 3'd0;
                            s.comma_seen   = 1'b0;
                        end else if (expo) begin
                            keep    = 1'b1;
                            s.phase = PH_EXP_START;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                end
                PH_FRAC_START: begin
                    if (dig) begin
                        s.group_digits  = 3'd1;
                        s.mantissa_seen = 1'b1;
                        keep            = 1'b1;
                        s.phase         = PH_FRAC;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_FRAC: begin
                    if (dig) begin
                        if (cur.group_digits < GROUP_SAT) begin
                            s.group_digits = cur.group_digits + 3'd1;
                        end
                        keep = 1'b1;
                    end else if (comma) begin
                        if (!cfg.frac_commas_on || cur.group_digits != GROUP_LEN) begin
                            bad = 1'b1;
                        end else begin
                            s.comma_seen   = 1'b1;
                            s.group_digits = 3'd0;
                        end
                    end else if (cur.group_digits == 3'd0 ||
                                 (cur.comma_seen && cur.group_digits > GROUP_LEN)) begin
                        bad = 1'b1;
                    end else if (expo) begin
                        keep    = 1'b1;
                        s.phase = PH_EXP_START;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_EXP_START: begin
                    if (sign) begin
                        keep    = 1'b1;
                        s.phase = PH_EXP_SIGN;
                    end else if (dig) begin
                        keep    = 1'b1;
                        s.phase = PH_EXP;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_EXP_SIGN, PH_EXP: begin
                    if (dig) begin
                        keep    = 1'b1;
                        s.phase = PH_EXP;
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    bad = 1'b1;
                end
            endcase

            // end of lexeme must close the grammar
            if (!bad && last) begin
                if (!(s.mantissa_seen &&
                      ((s.phase == PH_INT &&
                        !(s.comma_seen && s.group_digits != GROUP_LEN)) ||
                       (s.phase == PH_FRAC && s.group_digits != 3'd0 &&
                        !(s.comma_seen && s.group_digits > GROUP_LEN)) ||
                       s.phase == PH_EXP))) begin
                    bad = 1'b1;
                end
            end
            if (bad) begin
                s.failed = 1'b1;
                keep     = 1'b0;
            end
        end

        // identifier path
        if (cur.position == POS_FIRST) begin
            s.path = (c == cfg.id_char && !last) ? PATH_ID : PATH_NUMBER;
        end else if (cur.path == PATH_ID) begin
            if (cur.position == POS_SECOND && c == CH_ZERO) begin
                s.path = PATH_NUMBER;
            end else if (!dig || cur.id_accum > ID_GROW_MAX) begin
                s.path = PATH_ID_FAILED;
            end else begin
                s.id_accum = acc_mul;
            end
        end

        if (cur.position != POS_LATER) begin
            s.position = cur.position + 2'd1;
        end

        nxt = s;
        if (last) begin
            nxt.position      = POS_FIRST;
            nxt.path          = PATH_UNDECIDED;
            nxt.phase         = PH_SIGN;
            nxt.group_digits  = 3'd0;
            nxt.comma_seen    = 1'b0;
            nxt.mantissa_seen = 1'b0;
            nxt.failed        = 1'b0;
            nxt.id_accum      = '0;
        end
    end

    // result item
    always_comb begin
        dout.char_out = c;
        dout.keep     = keep;
        dout.done_res = last;
        dout.kind     = KIND_TEXT;
        dout.id_value = '0;
        if (last) begin
            if (s.path == PATH_ID) begin
                dout.kind     = KIND_ID;
                dout.id_value = s.id_accum;
            end else if (s.path == PATH_NUMBER && !s.failed &&
                         (cfg.int_commas_on || cfg.frac_commas_on)) begin
                dout.kind = KIND_NUM;
            end
        end
    end

endmodule

`default_nettype wire
